// ----- sv/obrs_pkg.sv -----
// Shared constants, types and helper functions for the occupancy bitmap rank
// and search unit. Used by every module except obrs_ram; depends on nothing.
package obrs_pkg;

  localparam int BLOCK_ROWS = 4096;
  localparam int WORD_COUNT = 64;
  localparam int WORD_W     = 64;
  localparam int BIT_W      = 6;
  localparam int MODE_W     = 3;
  localparam int OFFSET_W   = 12;
  localparam int RANK_W     = 12;
  localparam int COUNT_W    = 13;
  localparam int POP_W      = 7;

  localparam int ROW_LIMIT  = (BLOCK_ROWS < WORD_COUNT * WORD_W) ? BLOCK_ROWS
                                                                : WORD_COUNT * WORD_W;
  localparam int WORDS_USED = (ROW_LIMIT + WORD_W - 1) / WORD_W;
  localparam int ADDR_W     = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int LIM_W      = $clog2(ROW_LIMIT + 1);
  localparam int ROW_W      = (LIM_W > OFFSET_W) ? LIM_W : OFFSET_W;
  localparam int WIX_W      = (ADDR_W > ROW_W - BIT_W) ? ADDR_W : ROW_W - BIT_W;

  localparam logic [WIX_W-1:0]  LIM_WORD  = WIX_W'(ROW_LIMIT / WORD_W);
  localparam logic [BIT_W-1:0]  LIM_BIT   = BIT_W'(ROW_LIMIT % WORD_W);
  localparam logic [ADDR_W-1:0] LAST_WORD = ADDR_W'(WORDS_USED - 1);

  typedef enum logic [MODE_W-1:0] {
    MODE_SET        = 3'd0,
    MODE_CLEAR      = 3'd1,
    MODE_RANK       = 3'd2,
    MODE_NEXT_OCC   = 3'd3,
    MODE_PREV_OCC   = 3'd4,
    MODE_NEXT_EMPTY = 3'd5,
    MODE_PREV_EMPTY = 3'd6
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [WIX_W-1:0] start_word;
    logic [BIT_W-1:0] start_bit;
    logic [WIX_W-1:0] end_word;
    logic [BIT_W-1:0] end_bit;
    logic [WIX_W-1:0] off_word;
    logic [BIT_W-1:0] off_bit;
    logic             in_block;
    logic             want;
    logic             down;
  } scan_ctl_t;

  typedef struct packed {
    logic [POP_W-1:0] rank_add;
    logic             hit;
    logic [BIT_W-1:0] hit_bit;
    logic             was;
  } word_res_t;

  function automatic logic [WORD_W-1:0] low_mask(input logic [BIT_W-1:0] n);
    return (WORD_W'(1) << n) - WORD_W'(1);
  endfunction

  function automatic logic [WORD_W-1:0] one_hot(input logic [BIT_W-1:0] n);
    return WORD_W'(1) << n;
  endfunction

endpackage

// ----- sv/occupancy_bitmap_rank_search_unit.sv -----
// Top level of the occupancy bitmap rank and search unit: sequencer, bitmap
// RAM, accumulators and result register. Depends on obrs_pkg, obrs_ram and
// obrs_word_eval.
//
// Usage: an input beat carries mode and offset; each one gives exactly one
// output beat with found, position, rank, was_occupied and occupied_total.
// The unit takes one beat at a time. After an input beat is taken, the
// sequencer walks the bitmap one 64-bit word per cycle from the lowest word
// upward through the single RAM read port, folding each word into the rank
// count and the search result. Each word goes through the RAM's registered
// read before it is folded in; in the finish state the sequencer then writes
// back any changed word, loads the result register and raises in_ready again.
// The result sits in an output register: the next input beat is taken while
// it waits, and a stalled receiver only holds the unit once the next result
// is ready to be loaded. Synchronous reset empties the bitmap at once through
// a valid bit per word, clears the row count and drops out_valid.
module occupancy_bitmap_rank_search_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [obrs_pkg::MODE_W-1:0]  mode,
  input  logic [obrs_pkg::OFFSET_W-1:0] offset,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         found,
  output logic [obrs_pkg::OFFSET_W-1:0] position,
  output logic [obrs_pkg::RANK_W-1:0]  rank,
  output logic                         was_occupied,
  output logic [obrs_pkg::COUNT_W-1:0] occupied_total
);

  obrs_pkg::state_t state;
  obrs_pkg::state_t state_next;

  logic                          accept;
  logic                          ram_re;
  logic                          finish_go;
  logic                          do_write;
  logic                          is_search;

  logic [obrs_pkg::MODE_W-1:0]   mode_q;
  logic [obrs_pkg::OFFSET_W-1:0] off_q;
  obrs_pkg::scan_ctl_t           ctl;
  obrs_pkg::scan_ctl_t           ctl_next;
  logic [obrs_pkg::ADDR_W-1:0]   rd_idx;
  logic [obrs_pkg::ADDR_W-1:0]   pend_idx;
  logic                          issue;
  logic                          pend;
  logic                          pend_vld;
  logic [obrs_pkg::WORD_COUNT-1:0] valid;
  logic [obrs_pkg::ROW_W-1:0]    rank_acc;
  logic                          hit_found;
  logic [obrs_pkg::ROW_W-1:0]    hit_pos;
  logic                          was_q;
  logic [obrs_pkg::WORD_W-1:0]   cur_word;
  logic [obrs_pkg::COUNT_W-1:0]  count;
  logic [obrs_pkg::COUNT_W-1:0]  count_next;

  logic [obrs_pkg::WORD_W-1:0]   rd_data;
  logic [obrs_pkg::WORD_W-1:0]   word_data;
  logic [obrs_pkg::WORD_W-1:0]   wdata;
  obrs_pkg::word_res_t           res;

  logic [obrs_pkg::ROW_W-1:0]    off_ext;
  logic                          inside_in;
  logic [obrs_pkg::ROW_W-1:0]    end_row;
  logic [obrs_pkg::ROW_W-1:0]    start_row;
  logic                          down_in;

  assign accept    = in_valid && in_ready;
  assign word_data = pend_vld ? rd_data : '0;

  always_comb begin
    off_ext   = obrs_pkg::ROW_W'(offset);
    inside_in = off_ext < obrs_pkg::ROW_W'(obrs_pkg::ROW_LIMIT);
    end_row   = inside_in ? off_ext : obrs_pkg::ROW_W'(obrs_pkg::ROW_LIMIT);
    down_in   = (mode == obrs_pkg::MODE_PREV_OCC) || (mode == obrs_pkg::MODE_PREV_EMPTY);
    if (down_in && !inside_in) begin
      start_row = obrs_pkg::ROW_W'(obrs_pkg::ROW_LIMIT - 1);
    end else begin
      start_row = off_ext;
    end
    ctl_next.start_word = obrs_pkg::WIX_W'(start_row >> obrs_pkg::BIT_W);
    ctl_next.start_bit  = start_row[obrs_pkg::BIT_W-1:0];
    ctl_next.end_word   = obrs_pkg::WIX_W'(end_row >> obrs_pkg::BIT_W);
    ctl_next.end_bit    = end_row[obrs_pkg::BIT_W-1:0];
    ctl_next.off_word   = obrs_pkg::WIX_W'(off_ext >> obrs_pkg::BIT_W);
    ctl_next.off_bit    = off_ext[obrs_pkg::BIT_W-1:0];
    ctl_next.in_block   = inside_in;
    ctl_next.want       = (mode == obrs_pkg::MODE_NEXT_OCC) || (mode == obrs_pkg::MODE_PREV_OCC);
    ctl_next.down       = down_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= obrs_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    ram_re     = 1'b0;
    finish_go  = 1'b0;
    case (state)
      obrs_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = obrs_pkg::ST_SCAN;
        end
      end
      obrs_pkg::ST_SCAN: begin
        ram_re = issue;
        if (pend && (pend_idx == obrs_pkg::LAST_WORD)) begin
          state_next = obrs_pkg::ST_FINISH;
        end
      end
      obrs_pkg::ST_FINISH: begin
        finish_go = !out_valid || out_ready;
        if (finish_go) begin
          state_next = obrs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = obrs_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    is_search = (mode_q == obrs_pkg::MODE_NEXT_OCC) || (mode_q == obrs_pkg::MODE_PREV_OCC) ||
                (mode_q == obrs_pkg::MODE_NEXT_EMPTY) || (mode_q == obrs_pkg::MODE_PREV_EMPTY);
    do_write  = ctl.in_block && (((mode_q == obrs_pkg::MODE_SET) && !was_q) ||
                                 ((mode_q == obrs_pkg::MODE_CLEAR) && was_q));
    if (mode_q == obrs_pkg::MODE_SET) begin
      wdata = cur_word | obrs_pkg::one_hot(ctl.off_bit);
    end else begin
      wdata = cur_word & ~obrs_pkg::one_hot(ctl.off_bit);
    end
    if (do_write && (mode_q == obrs_pkg::MODE_SET)) begin
      count_next = count + obrs_pkg::COUNT_W'(1);
    end else if (do_write) begin
      count_next = count - obrs_pkg::COUNT_W'(1);
    end else begin
      count_next = count;
    end
  end

  obrs_ram #(
    .WIDTH (obrs_pkg::WORD_W),
    .DEPTH (obrs_pkg::WORD_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (finish_go && do_write),
    .waddr (ctl.off_word[obrs_pkg::ADDR_W-1:0]),
    .wdata (wdata),
    .re    (ram_re),
    .raddr (rd_idx),
    .rdata (rd_data)
  );

  obrs_word_eval u_eval (
    .word_idx (pend_idx),
    .word     (word_data),
    .ctl      (ctl),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      issue     <= 1'b0;
      pend      <= 1'b0;
      valid     <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      pend <= ram_re;
      if (accept) begin
        mode_q    <= mode;
        off_q     <= offset;
        ctl       <= ctl_next;
        rd_idx    <= '0;
        issue     <= 1'b1;
        rank_acc  <= '0;
        hit_found <= 1'b0;
        hit_pos   <= '0;
        was_q     <= 1'b0;
        cur_word  <= '0;
      end
      if (ram_re) begin
        pend_idx <= rd_idx;
        pend_vld <= valid[rd_idx];
        if (rd_idx == obrs_pkg::LAST_WORD) begin
          issue <= 1'b0;
        end else begin
          rd_idx <= rd_idx + obrs_pkg::ADDR_W'(1);
        end
      end
      if (pend) begin
        rank_acc <= rank_acc + obrs_pkg::ROW_W'(res.rank_add);
        was_q    <= was_q | res.was;
        if (res.hit && (ctl.down || !hit_found)) begin
          hit_found <= 1'b1;
          hit_pos   <= (obrs_pkg::ROW_W'(pend_idx) << obrs_pkg::BIT_W) |
                       obrs_pkg::ROW_W'(res.hit_bit);
        end
        if (obrs_pkg::WIX_W'(pend_idx) == ctl.off_word) begin
          cur_word <= word_data;
        end
      end
      if (finish_go) begin
        if (do_write) begin
          valid[ctl.off_word[obrs_pkg::ADDR_W-1:0]] <= 1'b1;
        end
        count          <= count_next;
        out_valid      <= 1'b1;
        found          <= is_search ? hit_found : 1'b1;
        position       <= (is_search && hit_found) ? hit_pos[obrs_pkg::OFFSET_W-1:0] : off_q;
        rank           <= rank_acc[obrs_pkg::RANK_W-1:0];
        was_occupied   <= was_q;
        occupied_total <= count_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- sv/obrs_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// Holds the bitmap words; depends on nothing.
module obrs_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/obrs_word_eval.sv -----
// Per-word evaluation unit: masked population count, first and last match
// search and bit pick-out for one bitmap word. Depends on obrs_pkg.
module obrs_word_eval (
  input  logic [obrs_pkg::ADDR_W-1:0] word_idx,
  input  logic [obrs_pkg::WORD_W-1:0] word,
  input  obrs_pkg::scan_ctl_t         ctl,
  output obrs_pkg::word_res_t         res
);

  logic [obrs_pkg::WIX_W-1:0]  idx;
  logic [obrs_pkg::WORD_W-1:0] rank_mask;
  logic [obrs_pkg::WORD_W-1:0] lim_mask;
  logic [obrs_pkg::WORD_W-1:0] rng_mask;
  logic [obrs_pkg::WORD_W-1:0] cand;
  logic [obrs_pkg::WORD_W-1:0] ranked;
  logic [obrs_pkg::BIT_W-1:0]  lo_bit;
  logic [obrs_pkg::BIT_W-1:0]  hi_bit;
  logic [obrs_pkg::POP_W-1:0]  pop;

  assign idx = obrs_pkg::WIX_W'(word_idx);

  always_comb begin
    if (idx < ctl.end_word) begin
      rank_mask = '1;
    end else if (idx == ctl.end_word) begin
      rank_mask = obrs_pkg::low_mask(ctl.end_bit);
    end else begin
      rank_mask = '0;
    end

    if (idx < obrs_pkg::LIM_WORD) begin
      lim_mask = '1;
    end else if (idx == obrs_pkg::LIM_WORD) begin
      lim_mask = obrs_pkg::low_mask(obrs_pkg::LIM_BIT);
    end else begin
      lim_mask = '0;
    end

    if (ctl.down) begin
      if (idx < ctl.start_word) begin
        rng_mask = '1;
      end else if (idx == ctl.start_word) begin
        rng_mask = obrs_pkg::low_mask(ctl.start_bit) | obrs_pkg::one_hot(ctl.start_bit);
      end else begin
        rng_mask = '0;
      end
    end else begin
      if (idx > ctl.start_word) begin
        rng_mask = '1;
      end else if (idx == ctl.start_word) begin
        rng_mask = ~obrs_pkg::low_mask(ctl.start_bit);
      end else begin
        rng_mask = '0;
      end
    end

    cand   = (ctl.want ? word : ~word) & lim_mask & rng_mask;
    ranked = word & rank_mask;

    pop = '0;
    for (int i = 0; i < obrs_pkg::WORD_W; i++) begin
      pop = pop + obrs_pkg::POP_W'(ranked[i]);
    end

    hi_bit = '0;
    for (int i = 0; i < obrs_pkg::WORD_W; i++) begin
      if (cand[i]) begin
        hi_bit = obrs_pkg::BIT_W'(i);
      end
    end

    lo_bit = '0;
    for (int i = obrs_pkg::WORD_W - 1; i >= 0; i--) begin
      if (cand[i]) begin
        lo_bit = obrs_pkg::BIT_W'(i);
      end
    end

    res.rank_add = pop;
    res.hit      = |cand;
    res.hit_bit  = ctl.down ? hi_bit : lo_bit;
    res.was      = ctl.in_block && (idx == ctl.off_word) && word[ctl.off_bit];
  end

endmodule

// ----- sv/obrs_checker.sv -----
// Port-level checker for the occupancy bitmap rank and search unit, with the
// bind that attaches it to the top level. Depends on the top level's ports.
module obrs_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         found,
  input logic [obrs_pkg::OFFSET_W-1:0] position,
  input logic [obrs_pkg::RANK_W-1:0]  rank,
  input logic                         was_occupied,
  input logic [obrs_pkg::COUNT_W-1:0] occupied_total
);

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("unit still ready after taking an input beat");

  a_reset_state: assert property (@(posedge clk)
    rst |=> (in_ready && !out_valid))
    else $error("unit not idle and empty after reset");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(found) && $stable(position) &&
                                   $stable(rank) && $stable(was_occupied) &&
                                   $stable(occupied_total)))
    else $error("stalled output beat changed");

  a_result_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("output beat appeared without a walk in progress");

endmodule

bind occupancy_bitmap_rank_search_unit obrs_checker u_obrs_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .found          (found),
  .position       (position),
  .rank           (rank),
  .was_occupied   (was_occupied),
  .occupied_total (occupied_total)
);
